[sv/rts_pkg.sv]
// Package of the reservation table scheduler: sizes, request codes, cell
// control type and the stage-to-unit decode. No dependencies.
`default_nettype none
package rts_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int STAGE_COUNT = 8;
  localparam int UNIT_COUNT  = 3;
  localparam int FIELD_COUNT = 8;
  localparam int SLOT_W      = 6;
  localparam int LEN_W       = 7;
  localparam int TOTAL_W     = 16;
  localparam int UNIT_W      = 2;

  // Request type codes.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DRAIN  = 1'b1;

  // Per-cycle control that the sequencer hands to one table cell.
  typedef struct packed {
    logic                  shift;
    logic [UNIT_COUNT-1:0] mark;
  } rts_cell_ctl_t;

  // A unit code at or above UNIT_COUNT uses no unit.
  function automatic logic [UNIT_COUNT-1:0] unit_mask(input logic [UNIT_W-1:0] u);
    logic [UNIT_COUNT-1:0] m;
    m = '0;
    if (u < UNIT_W'(UNIT_COUNT)) begin
      m[u] = 1'b1;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

[sv/reservation_table_scheduler_unit.sv]
// Top level of the reservation table scheduler: request sequencer, a ring
// of rts_cell slots, per-unit totals and the result register. Uses rts_pkg.
//
//  channel | direction | ports
//  --------+-----------+---------------------------------------------------
//  in      | input     | in_valid, in_stall, in_req_type, in_stage*_unit,
//          |           | in_min_start
//  out     | output    | out_valid, out_stall, out_start_slot, ...totals
//
// An insert turns the 64-cell ring once around, one slot per cycle, testing the
// eight-slot window at the front; when the turn is done, its result is
// registered as soon as the output register is free. A drain's result is
// registered from the drain state in the same way. The next beat is taken once
// the previous result is in the output register, even while it waits behind
// out_stall. Reset clears the table, the length and the totals at once.
`default_nettype none
module reservation_table_scheduler_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_req_type,
  input  wire logic [rts_pkg::UNIT_W-1:0]  in_stage0_unit,
  input  wire logic [rts_pkg::UNIT_W-1:0]  in_stage1_unit,
  input  wire logic [rts_pkg::UNIT_W-1:0]  in_stage2_unit,
  input  wire logic [rts_pkg::UNIT_W-1:0]  in_stage3_unit,
  input  wire logic [rts_pkg::UNIT_W-1:0]  in_stage4_unit,
  input  wire logic [rts_pkg::UNIT_W-1:0]  in_stage5_unit,
  input  wire logic [rts_pkg::UNIT_W-1:0]  in_stage6_unit,
  input  wire logic [rts_pkg::UNIT_W-1:0]  in_stage7_unit,
  input  wire logic [rts_pkg::SLOT_W-1:0]  in_min_start,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [rts_pkg::SLOT_W-1:0]  out_start_slot,
  output logic      [rts_pkg::LEN_W-1:0]   out_table_length,
  output logic                             out_overflow,
  output logic                             out_empty_drain,
  output logic      [rts_pkg::UNIT_COUNT-1:0] out_slot_busy_bits,
  output logic      [rts_pkg::TOTAL_W-1:0] out_unit0_total,
  output logic      [rts_pkg::TOTAL_W-1:0] out_unit1_total,
  output logic      [rts_pkg::TOTAL_W-1:0] out_unit2_total
);
  import rts_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_DRAIN  = 2'd3;

  localparam logic [SLOT_W-1:0] LAST_FIT  = SLOT_W'(TABLE_DEPTH - STAGE_COUNT);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  logic [1:0]            state_r;
  logic [SLOT_W-1:0]     cnt_r;
  logic                  done_r;
  logic                  ovf_r;
  logic [SLOT_W-1:0]     start_r;
  logic [SLOT_W-1:0]     min_start_r;
  logic [UNIT_COUNT-1:0] stage_mask_r [FIELD_COUNT];
  logic [LEN_W-1:0]      len_r;
  logic [LEN_W-1:0]      len_nxt;
  logic [TOTAL_W-1:0]    tot_r   [UNIT_COUNT];
  logic [TOTAL_W-1:0]    tot_nxt [UNIT_COUNT];

  logic                  out_valid_r;
  logic [SLOT_W-1:0]     out_start_r;
  logic [LEN_W-1:0]      out_len_r;
  logic                  out_ovf_r;
  logic                  out_empty_r;
  logic [UNIT_COUNT-1:0] out_bits_r;
  logic [TOTAL_W-1:0]    out_tot_r [UNIT_COUNT];

  logic                  in_acc;
  logic                  out_free;
  logic                  commit_ins;
  logic                  commit_dr;
  logic                  do_drain;
  logic                  try_fit;
  logic                  no_room;
  logic                  fit;
  logic                  hit;
  logic                  ring;
  logic [LEN_W-1:0]      end_len;
  logic [UNIT_COUNT-1:0] stage_in [FIELD_COUNT];

  rts_cell_ctl_t         ctl   [TABLE_DEPTH];
  logic [UNIT_COUNT-1:0] busy  [TABLE_DEPTH];
  logic [UNIT_COUNT-1:0] pass  [TABLE_DEPTH];
  logic [UNIT_COUNT-1:0] nbr   [TABLE_DEPTH];

  assign stage_in[0] = unit_mask(in_stage0_unit);
  assign stage_in[1] = unit_mask(in_stage1_unit);
  assign stage_in[2] = unit_mask(in_stage2_unit);
  assign stage_in[3] = unit_mask(in_stage3_unit);
  assign stage_in[4] = unit_mask(in_stage4_unit);
  assign stage_in[5] = unit_mask(in_stage5_unit);
  assign stage_in[6] = unit_mask(in_stage6_unit);
  assign stage_in[7] = unit_mask(in_stage7_unit);

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign commit_ins = (state_r == ST_FINISH) && out_free;
  assign commit_dr  = (state_r == ST_DRAIN) && out_free;
  assign do_drain   = commit_dr && (len_r != '0);
  assign ring       = (state_r == ST_SCAN);

  // The window is the front STAGE_COUNT cells; the front cell holds slot cnt_r.
  always_comb begin
    fit = 1'b1;
    for (int s = 0; s < STAGE_COUNT; s++) begin
      if ((busy[s] & stage_mask_r[s % FIELD_COUNT]) != '0) begin
        fit = 1'b0;
      end
    end
  end

  assign try_fit = ring && !done_r && (cnt_r >= min_start_r);
  assign no_room = (cnt_r > LAST_FIT);
  assign hit     = try_fit && !no_room && fit;
  assign end_len = {1'b0, cnt_r} + LEN_W'(STAGE_COUNT);

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ctl[i].shift = ring || do_drain;
      ctl[i].mark  = '0;
    end
    for (int s = 0; s < STAGE_COUNT; s++) begin
      ctl[s].mark = hit ? stage_mask_r[s % FIELD_COUNT] : '0;
    end
  end

  // Each cell loads from the next one; the last closes the ring while
  // scanning and takes a free slot on a drain.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
      nbr[i] = pass[i + 1];
    end
    nbr[TABLE_DEPTH - 1] = ring ? pass[0] : '0;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    rts_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl[g]),
      .nbr_i  (nbr[g]),
      .busy_o (busy[g]),
      .pass_o (pass[g])
    );
  end

  always_comb begin
    len_nxt = len_r;
    if (hit && (end_len > len_r)) begin
      len_nxt = end_len;
    end else if (do_drain) begin
      len_nxt = len_r - LEN_W'(1);
    end
    for (int u = 0; u < UNIT_COUNT; u++) begin
      tot_nxt[u] = tot_r[u];
      if (do_drain && busy[0][u] && (tot_r[u] != TOTAL_MAX)) begin
        tot_nxt[u] = tot_r[u] + TOTAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
      ovf_r   <= 1'b0;
      len_r   <= '0;
      for (int u = 0; u < UNIT_COUNT; u++) begin
        tot_r[u] <= '0;
      end
    end else begin
      len_r <= len_nxt;
      for (int u = 0; u < UNIT_COUNT; u++) begin
        tot_r[u] <= tot_nxt[u];
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cnt_r   <= '0;
            done_r  <= 1'b0;
            ovf_r   <= 1'b0;
            state_r <= (in_req_type == REQ_DRAIN) ? ST_DRAIN : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            done_r <= 1'b1;
          end else if (try_fit && no_room) begin
            done_r <= 1'b1;
            ovf_r  <= 1'b1;
          end
          cnt_r <= cnt_r + SLOT_W'(1);
          if (cnt_r == LAST_SLOT) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (commit_ins) begin
            state_r <= ST_IDLE;
          end
        end
        ST_DRAIN: begin
          if (commit_dr) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Request payload and the chosen start slot.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      min_start_r <= in_min_start;
      for (int f = 0; f < FIELD_COUNT; f++) begin
        stage_mask_r[f] <= stage_in[f];
      end
    end
    if (in_acc) begin
      start_r <= '0;
    end else if (hit) begin
      start_r <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit_ins || commit_dr) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_ins) begin
      out_start_r <= ovf_r ? '0 : start_r;
      out_len_r   <= len_r;
      out_ovf_r   <= ovf_r;
      out_empty_r <= 1'b0;
      out_bits_r  <= '0;
      for (int u = 0; u < UNIT_COUNT; u++) begin
        out_tot_r[u] <= tot_r[u];
      end
    end else if (commit_dr) begin
      out_start_r <= '0;
      out_len_r   <= len_nxt;
      out_ovf_r   <= 1'b0;
      out_empty_r <= (len_r == '0);
      out_bits_r  <= (len_r == '0) ? '0 : busy[0];
      for (int u = 0; u < UNIT_COUNT; u++) begin
        out_tot_r[u] <= tot_nxt[u];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_start_slot     = out_start_r;
  assign out_table_length   = out_len_r;
  assign out_overflow       = out_ovf_r;
  assign out_empty_drain    = out_empty_r;
  assign out_slot_busy_bits = out_bits_r;
  assign out_unit0_total    = out_tot_r[0];
  assign out_unit1_total    = out_tot_r[1];
  assign out_unit2_total    = out_tot_r[2];

endmodule
`default_nettype wire

[sv/rts_cell.sv]
// One slot of the reservation table: its unit-busy bits, loaded from the
// neighbor on a shift. Uses rts_pkg.
`default_nettype none
module rts_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rts_pkg::rts_cell_ctl_t        ctl,
  input  wire logic [rts_pkg::UNIT_COUNT-1:0] nbr_i,
  output logic      [rts_pkg::UNIT_COUNT-1:0] busy_o,
  output logic      [rts_pkg::UNIT_COUNT-1:0] pass_o
);
  import rts_pkg::*;

  logic [UNIT_COUNT-1:0] busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (ctl.shift) begin
      busy_r <= nbr_i;
    end
  end

  assign busy_o = busy_r;
  // New reservations ride along with the value handed to the neighbor.
  assign pass_o = busy_r | ctl.mark;

endmodule
`default_nettype wire
